/* src/praq_pkg.sv */
// shared constants, types and codes of the priority ready queue
`default_nettype none
package praq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_W      = 6;
  localparam int SLICE_W     = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W       = 6;

  localparam logic [SLICE_W-1:0] SLICE_MAX         = 4'd15;
  localparam logic [SLICE_W-1:0] SLICE_LIMIT_RESET = 4'd4;
  localparam logic [PRIO_W-1:0]  TOP_PRIO_RESET    = 6'd63;
  localparam logic [CNT_W-1:0]   FULL_COUNT        = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_TICK   = 2'd2,
    OP_REPRIO = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_AGING_ENABLE = 2'd0,
    CFG_SLICE_LIMIT  = 2'd1,
    CFG_TOP_PRIORITY = 2'd2
  } cfg_idx_e;

  // what every cell of the chain does with the broadcast command
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_AGE    = 2'd3
  } cell_op_e;

  typedef enum logic {
    CTL_IDLE     = 1'b0,
    CTL_REINSERT = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // flags handed from a cell to its right neighbor
  typedef struct packed {
    logic ge;
    logic hit;
  } link_t;

  // command broadcast to all cells
  typedef struct packed {
    cell_op_e          op;
    entry_t            key;
    logic [PRIO_W-1:0] top;
  } cmd_t;

endpackage
`default_nettype wire

/* src/praq_cell.sv */
// one queue slot: holds an entry and trades it with its neighbors
`default_nettype none
module praq_cell (
  input  wire logic            clk,
  input  wire praq_pkg::cmd_t  cmd,
  input  wire logic            valid,
  input  wire praq_pkg::entry_t left_ent,
  input  wire praq_pkg::link_t  left_link,
  input  wire praq_pkg::entry_t right_ent,
  output praq_pkg::entry_t     ent,
  output praq_pkg::link_t      link_out
);
  import praq_pkg::*;

  entry_t ent_next;

  // flags seen by the right neighbor
  always_comb begin
    link_out.ge  = valid && (ent.prio >= cmd.key.prio);
    link_out.hit = left_link.hit || (valid && (ent.id == cmd.key.id));
  end

  // slot update
  always_comb begin
    ent_next = ent;
    case (cmd.op)
      CELL_INSERT: begin
        if (!link_out.ge) begin
          ent_next = left_link.ge ? cmd.key : left_ent;
        end
      end
      CELL_REMOVE: begin
        if (link_out.hit) begin
          ent_next = right_ent;
        end
      end
      CELL_AGE: begin
        if (valid && (ent.prio < cmd.top)) begin
          ent_next.prio = ent.prio + PRIO_W'(1);
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule
`default_nettype wire

/* src/praq_chain.sv */
// row of queue slots kept in descending priority order
`default_nettype none
module praq_chain (
  input  wire logic                     clk,
  input  wire praq_pkg::cmd_t           cmd,
  input  wire logic                     seed_hit,
  input  wire logic [praq_pkg::CNT_W-1:0] count,
  output praq_pkg::entry_t              head,
  output logic                          found
);
  import praq_pkg::*;

  entry_t ent   [QUEUE_DEPTH];
  link_t  links [QUEUE_DEPTH+1];

  // head of the chain: insert lands at slot 0 unless passed, pop removes slot 0
  assign links[0] = {1'b1, seed_hit};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;

    if (i == 0) begin : g_first
      assign left_e = cmd.key;
    end else begin : g_mid
      assign left_e = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ent[i+1];
    end

    praq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .valid     (count > CNT_W'(i)),
      .left_ent  (left_e),
      .left_link (links[i]),
      .right_ent (right_e),
      .ent       (ent[i]),
      .link_out  (links[i+1])
    );
  end

  assign head  = ent[0];
  assign found = links[QUEUE_DEPTH].hit;

endmodule
`default_nettype wire

/* src/priority_ready_queue_aging_unit.sv */
// top level of the priority ready queue with aging and time slice
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | start / busy       | op, task_id, prio
//  result   | done (one cycle)   | status, out_id, out_prio, head_valid,
//           |                    | head_prio, yield_req, fill
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// for insert, pop and tick the result beat comes in the cycle after the command is taken.
// reprioritize of a found id makes a remove pass along the cell chain, then an insert
// pass in the reinsert state with busy high; if the id is absent, only the remove pass.
// rst clears entry count, slice count and control state, and loads the config reset values.
// the receiver cannot stall; config ready is always high.
`default_nettype none
module priority_ready_queue_aging_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [7:0] task_id,
  input  wire logic [5:0] prio,
  output logic            done,
  output logic [1:0]      status,
  output logic [7:0]      out_id,
  output logic [5:0]      out_prio,
  output logic            head_valid,
  output logic [5:0]      head_prio,
  output logic            yield_req,
  output logic [4:0]      fill,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [praq_pkg::CFG_W-1:0] cfg_data
);
  import praq_pkg::*;

  ctl_state_e         state;
  ctl_state_e         state_next;
  logic [CNT_W-1:0]   count;
  logic [SLICE_W-1:0] slice_count;
  logic               aging_enable;
  logic [SLICE_W-1:0] slice_limit;
  logic [PRIO_W-1:0]  top_priority;
  entry_t             key;
  entry_t             in_ent;
  entry_t             head;
  cmd_t               cmd;
  logic               seed_hit;
  logic               found;
  logic               accept;
  op_e                op_in;

  assign op_in     = op_e'(op);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_ent.id   = ID_BITS'(task_id);
    in_ent.prio = prio;
  end

  praq_chain u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .seed_hit (seed_hit),
    .count    (count),
    .head     (head),
    .found    (found)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (accept && (op_in == OP_REPRIO) && found) begin
          state_next = CTL_REINSERT;
        end
      end
      CTL_REINSERT: begin
        state_next = CTL_IDLE;
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  // chain command and busy
  always_comb begin
    busy     = 1'b0;
    seed_hit = 1'b0;
    cmd.op   = CELL_HOLD;
    cmd.key  = in_ent;
    cmd.top  = top_priority;
    case (state)
      CTL_IDLE: begin
        if (start) begin
          case (op_in)
            OP_INSERT: begin
              if (count != FULL_COUNT) begin
                cmd.op = CELL_INSERT;
              end
            end
            OP_POP: begin
              cmd.op   = CELL_REMOVE;
              seed_hit = 1'b1;
            end
            OP_TICK: begin
              if (aging_enable) begin
                cmd.op = CELL_AGE;
              end
            end
            OP_REPRIO: begin
              cmd.op = CELL_REMOVE;
            end
            default: begin
              cmd.op = CELL_HOLD;
            end
          endcase
        end
      end
      CTL_REINSERT: begin
        busy    = 1'b1;
        cmd.op  = CELL_INSERT;
        cmd.key = key;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CTL_IDLE;
      count        <= '0;
      slice_count  <= '0;
      done         <= 1'b0;
      aging_enable <= 1'b0;
      slice_limit  <= SLICE_LIMIT_RESET;
      top_priority <= TOP_PRIO_RESET;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_AGING_ENABLE: aging_enable <= cfg_data[0];
          CFG_SLICE_LIMIT:  slice_limit  <= cfg_data[SLICE_W-1:0];
          CFG_TOP_PRIORITY: top_priority <= cfg_data[PRIO_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == CTL_REINSERT) begin
        count <= count + CNT_W'(1);
        done  <= 1'b1;
      end else if (accept) begin
        case (op_in)
          OP_INSERT: begin
            if (count != FULL_COUNT) begin
              count <= count + CNT_W'(1);
            end
            done <= 1'b1;
          end
          OP_POP: begin
            if (count != '0) begin
              count <= count - CNT_W'(1);
            end
            slice_count <= '0;
            done        <= 1'b1;
          end
          OP_TICK: begin
            if (slice_count < SLICE_MAX) begin
              slice_count <= slice_count + SLICE_W'(1);
            end
            done <= 1'b1;
          end
          OP_REPRIO: begin
            if (found) begin
              count <= count - CNT_W'(1);
            end else begin
              done <= 1'b1;
            end
          end
          default: begin
            done <= 1'b0;
          end
        endcase
      end
    end
  end

  // result payload and held reprioritize key
  always_ff @(posedge clk) begin
    if (state == CTL_REINSERT) begin
      status   <= ST_OK;
      out_id   <= '0;
      out_prio <= '0;
    end else if (accept) begin
      status   <= ST_OK;
      out_id   <= '0;
      out_prio <= '0;
      key      <= in_ent;
      case (op_in)
        OP_INSERT: begin
          if (count == FULL_COUNT) begin
            status <= ST_FULL;
          end
        end
        OP_POP: begin
          if (count == '0) begin
            status <= ST_EMPTY;
          end else begin
            out_id   <= 8'(head.id);
            out_prio <= head.prio;
          end
        end
        OP_REPRIO: begin
          if (!found) begin
            status <= ST_NOTFOUND;
          end
        end
        default: begin
          status <= ST_OK;
        end
      endcase
    end
  end

  // queue summary seen with each result beat
  assign head_valid = (count != '0);
  assign head_prio  = head_valid ? head.prio : '0;
  assign yield_req  = (slice_count >= slice_limit);
  assign fill       = 5'(count);

`ifndef ASSERT_OFF
  a_reinsert_single: assert property (@(posedge clk) disable iff (rst)
    busy |-> !$past(busy))
    else $error("reinsert pass lasted more than one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond queue depth");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (count == FULL_COUNT))
    else $error("drop reported while queue had room");

  a_empty_means_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY)) |-> !head_valid)
    else $error("empty pop reported with entries queued");

  a_reinsert_after_remove: assert property (@(posedge clk) disable iff (rst)
    busy |-> ($past(count) == count + CNT_W'(1)))
    else $error("reinsert not preceded by a removal");
`endif

endmodule
`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for the priority ready queue with aging and time slice
`timescale 1ns / 100ps
module tb_top;
  import praq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int END_SETTLE     = 4;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_id;
    logic [5:0] out_prio;
    logic       head_valid;
    logic [5:0] head_prio;
    logic       yield_req;
    logic [4:0] fill;
  } sched_result_t;

  // dut ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         op = '0;
  logic [7:0]         task_id = '0;
  logic [5:0]         prio = '0;
  logic               done;
  logic [1:0]         status;
  logic [7:0]         out_id;
  logic [5:0]         out_prio;
  logic               head_valid;
  logic [5:0]         head_prio;
  logic               yield_req;
  logic [4:0]         fill;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // shadow copy of the ready queue and registers
  logic [ID_BITS-1:0] rq_ids   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  rq_prios [QUEUE_DEPTH];
  int                 rq_count  = 0;
  int                 slice_cnt = 0;
  logic               aging_on  = 1'b0;
  logic [3:0]         slice_lim = SLICE_LIMIT_RESET;
  logic [5:0]         top_lvl   = TOP_PRIO_RESET;

  // results still owed by the block, oldest first
  sched_result_t sched_results_due[$];

  int mismatches   = 0;
  int idle_cycles  = 0;
  int op_count[4]  = '{0, 0, 0, 0};
  int full_drops   = 0;
  int empty_pops   = 0;
  int missing_ids  = 0;
  int yield_seen   = 0;
  int settings     = 0;
  int burst_left   = 0;
  bit no_idle      = 1'b0;

  priority_ready_queue_aging_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .task_id    (task_id),
    .prio       (prio),
    .done       (done),
    .status     (status),
    .out_id     (out_id),
    .out_prio   (out_prio),
    .head_valid (head_valid),
    .head_prio  (head_prio),
    .yield_req  (yield_req),
    .fill       (fill),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // queue bookkeeping: entry goes behind all of equal or higher priority
  function automatic void place_entry(logic [7:0] id, logic [5:0] p);
    int pos;
    pos = 0;
    while (pos < rq_count && rq_prios[pos] >= p) pos++;
    for (int k = rq_count; k > pos; k--) begin
      rq_ids[k]   = rq_ids[k-1];
      rq_prios[k] = rq_prios[k-1];
    end
    rq_ids[pos]   = id;
    rq_prios[pos] = p;
    rq_count++;
  endfunction

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < rq_count; k++) begin
      rq_ids[k]   = rq_ids[k+1];
      rq_prios[k] = rq_prios[k+1];
    end
    rq_count--;
  endfunction

  // one scheduler operation on the shadow state, returns the owed result
  function automatic sched_result_t apply_sched_op(op_e o, logic [7:0] id, logic [5:0] p);
    sched_result_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    case (o)
      OP_INSERT: begin
        if (rq_count >= QUEUE_DEPTH) r.status = ST_FULL;
        else place_entry(id, p);
      end
      OP_POP: begin
        if (rq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_id   = rq_ids[0];
          r.out_prio = rq_prios[0];
          drop_entry(0);
        end
        slice_cnt = 0;
      end
      OP_TICK: begin
        if (slice_cnt < SLICE_MAX) slice_cnt++;
        // aging keeps the order, no re-sort
        if (aging_on) begin
          for (int k = 0; k < rq_count; k++)
            if (rq_prios[k] < top_lvl) rq_prios[k]++;
        end
      end
      default: begin
        pos = 0;
        while (pos < rq_count && rq_ids[pos] != id) pos++;
        if (pos >= rq_count) begin
          r.status = ST_NOTFOUND;
        end else begin
          drop_entry(pos);
          place_entry(id, p);
        end
      end
    endcase
    r.head_valid = (rq_count > 0);
    r.head_prio  = (rq_count > 0) ? rq_prios[0] : '0;
    r.yield_req  = (slice_cnt >= slice_lim);
    r.fill       = 5'(rq_count);
    return r;
  endfunction

  function automatic string fmt_result(sched_result_t r);
    return $sformatf({"status=%0d out_id=%0d out_prio=%0d head_valid=%0d",
                      " head_prio=%0d yield=%0d fill=%0d"},
                     r.status, r.out_id, r.out_prio, r.head_valid, r.head_prio, r.yield_req,
                     r.fill);
  endfunction

  // sender gap: stretches of back-to-back beats mixed with random idling
  function automatic int next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 60);
      no_idle    = ($urandom_range(0, 9) < 3);
    end
    burst_left--;
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // drive one command beat and wait for it to be taken
  task automatic send_cmd(op_e o, logic [7:0] id, logic [5:0] p);
    int gap;
    sched_result_t r;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    op      <= o;
    task_id <= id;
    prio    <= p;
    do @(posedge clk); while (busy);
    r = apply_sched_op(o, id, p);
    sched_results_due.push_back(r);
    op_count[o]++;
    if (r.status == ST_FULL) full_drops++;
    if (r.status == ST_EMPTY) empty_pops++;
    if (r.status == ST_NOTFOUND) missing_ids++;
    if (r.yield_req) yield_seen++;
  endtask

  // let every owed result come back before touching registers
  task automatic drain();
    start <= 1'b0;
    while (sched_results_due.size() != 0) @(posedge clk);
  endtask

  // valid stays high for a following beat; the caller drops it after the last one
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AGING_ENABLE: aging_on  = data[0];
      CFG_SLICE_LIMIT:  slice_lim = data[3:0];
      CFG_TOP_PRIORITY: top_lvl   = data[5:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry random values
  task automatic set_config(logic a, logic [3:0] s, logic [5:0] t);
    drain();
    write_reg(CFG_AGING_ENABLE, CFG_W'($urandom_range(0, 31) << 1) | CFG_W'(a));
    write_reg(CFG_SLICE_LIMIT, CFG_W'($urandom_range(0, 3) << 4) | CFG_W'(s));
    write_reg(CFG_TOP_PRIORITY, t);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // small id pool gives duplicates and reprioritize hits
  function automatic logic [7:0] pick_id();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [5:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return 6'd0;
      1: return 6'd63;
      2: return top_lvl;
      3: return top_lvl + 6'd1;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // random traffic with a weighted operation mix
  task automatic run_traffic(int n, int w_ins, int w_pop, int w_tick, int w_rep);
    int sel;
    logic [7:0] id;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, w_ins + w_pop + w_tick + w_rep - 1);
      if (sel < w_ins) begin
        send_cmd(OP_INSERT, pick_id(), pick_prio());
      end else if (sel < w_ins + w_pop) begin
        send_cmd(OP_POP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      end else if (sel < w_ins + w_pop + w_tick) begin
        send_cmd(OP_TICK, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      end else begin
        id = pick_id();
        if (rq_count > 0 && $urandom_range(0, 9) < 7)
          id = rq_ids[$urandom_range(0, rq_count - 1)];
        send_cmd(OP_REPRIO, id, pick_prio());
      end
    end
  endtask

  // ordering, fifo among equals, duplicates, empty and absent cases at reset settings
  task automatic test_directed();
    write_reg(CFG_UNUSED_IDX, 6'h3f);
    cfg_valid <= 1'b0;
    send_cmd(OP_POP, 8'd0, 6'd0);
    send_cmd(OP_TICK, 8'd255, 6'd63);
    send_cmd(OP_INSERT, 8'd255, 6'd63);
    send_cmd(OP_INSERT, 8'd0, 6'd0);
    send_cmd(OP_INSERT, 8'haa, 6'd0);
    send_cmd(OP_INSERT, 8'h55, 6'd63);
    send_cmd(OP_INSERT, 8'haa, 6'd40);
    send_cmd(OP_REPRIO, 8'haa, 6'd63);
    send_cmd(OP_REPRIO, 8'h33, 6'd5);
    send_cmd(OP_REPRIO, 8'd0, 6'd63);
    repeat (4) send_cmd(OP_TICK, 8'd0, 6'd0);
    repeat (7) send_cmd(OP_POP, 8'd0, 6'd0);
  endtask

  // yield at slice limits zero, one and fifteen, counter saturation
  task automatic test_slice_limits();
    set_config(1'b0, 4'd0, 6'd63);
    run_traffic(120, 3, 1, 6, 1);
    set_config(1'b0, 4'd1, 6'd63);
    run_traffic(120, 3, 1, 6, 1);
    set_config(1'b0, 4'd15, 6'd63);
    run_traffic(120, 3, 1, 8, 1);
  endtask

  // aging against low, high and middle ceilings
  task automatic test_aging_ceiling();
    set_config(1'b1, 4'd4, 6'd0);
    run_traffic(180, 4, 2, 4, 2);
    set_config(1'b1, 4'd7, 6'd63);
    run_traffic(180, 4, 2, 4, 2);
    set_config(1'b1, 4'd2, 6'd20);
    run_traffic(180, 4, 2, 4, 2);
  endtask

  // run into a full queue, then drain past empty
  task automatic test_full_and_empty();
    set_config(1'b0, 4'd4, 6'd63);
    run_traffic(150, 8, 1, 1, 2);
    set_config(1'b1, 4'd15, 6'd40);
    run_traffic(150, 1, 6, 2, 1);
  endtask

  task automatic test_mixed_random();
    repeat (3) begin
      set_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 6'($urandom_range(0, 63)));
      run_traffic(130, 4, 3, 3, 2);
    end
  endtask

  // result checker: every beat against the oldest owed result
  always @(posedge clk) begin : result_check
    sched_result_t got, want;
    if (!rst && done) begin
      got = {status_e'(status), out_id, out_prio, head_valid, head_prio, yield_req, fill};
      if (sched_results_due.size() == 0) begin
        if (mismatches < MAX_REPORTS) $display("unexpected result beat: %s", fmt_result(got));
        mismatches++;
      end else begin
        want = sched_results_due.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sched_results_due.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_slice_limits();
    test_aging_ceiling();
    test_full_and_empty();
    test_mixed_random();
    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("ran %0d inserts, %0d pops, %0d ticks, %0d reprioritizes over %0d settings",
             op_count[OP_INSERT], op_count[OP_POP], op_count[OP_TICK], op_count[OP_REPRIO],
             settings);
    $display("%0d full drops, %0d empty pops, %0d absent ids, %0d yields, %0d mismatches",
             full_drops, empty_pops, missing_ids, yield_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
